### rtl/bsh_pkg.sv
// ----------------------------------------------------------------------------
// bsh_pkg
// Shared types and constants of the bit symbol histogram.
// ----------------------------------------------------------------------------
package bsh_pkg;

    localparam int MAX_SYMBOL_BITS = 12;
    localparam int COUNT_BITS      = 32;
    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int BYTE_W          = 8;
    localparam int WIDTH_W         = 4;
    localparam int LEFT_W          = 4;

    localparam logic [WIDTH_W-1:0] RESET_SYMBOL_WIDTH = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOL_WIDTH     = 3'd0,
        CFG_MAP_KINDS        = 3'd1,
        CFG_FIRST_FROM_LOW   = 3'd2,
        CFG_FIRST_FROM_HIGH  = 3'd3,
        CFG_FIRST_TO_START   = 3'd4,
        CFG_SECOND_FROM_LOW  = 3'd5,
        CFG_SECOND_FROM_HIGH = 3'd6,
        CFG_SECOND_TO_START  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MAP_OFF  = 2'd0,
        MAP_ASC  = 2'd1,
        MAP_DESC = 2'd2,
        MAP_ONE  = 2'd3
    } t_map_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SHIFT,
        S_READ,
        S_UPDATE,
        S_OUT
    } t_bsh_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } t_unp_ctl;

    typedef struct packed {
        logic sym_done;
        logic run_last;
        logic byte_end;
        logic byte_done;
    } t_unp_sts;

endpackage

### rtl/bit_symbol_histogram_top.sv
// ----------------------------------------------------------------------------
// bit_symbol_histogram_top
// Cuts a byte stream into symbols, remaps them and keeps a saturating
// histogram of the mapped symbols; read items return one bin.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_mode, i_data_byte,
//                                             i_end_of_stream, i_bin_index
//   result    out        o_valid / i_stall    o_reply_kind, o_symbol_value,
//                                             o_bin_count, o_last_of_run
//   config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// a stream byte is shifted out bit by bit, and each symbol it yields goes
// through the histogram read-modify-write (read, update, out), held in out
// while its result is stalled; a read item passes read, update and out
// after reset the histogram is cleared one bin a cycle, all 2**SYM_W bins
// (4096 by default), while o_stall stays high
// one item is in work at a time; o_stall is low only while idle
// ----------------------------------------------------------------------------
module bit_symbol_histogram_top #(
    parameter int SYM_W = bsh_pkg::MAX_SYMBOL_BITS,
    parameter int CNT_W = bsh_pkg::COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [bsh_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_end_of_stream,
    input  logic [SYM_W-1:0]               i_bin_index,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_reply_kind,
    output logic [SYM_W-1:0]               o_symbol_value,
    output logic [CNT_W-1:0]               o_bin_count,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_we,
    input  logic [bsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsh_pkg::CFG_W-1:0]      i_cfg_data
);

    import bsh_pkg::*;

    localparam int DEPTH = 1 << SYM_W;
    localparam int HW    = $clog2(SYM_W + 1);
    localparam int WW    = (HW > WIDTH_W) ? HW : WIDTH_W;

    logic [WIDTH_W-1:0] r_symbol_width;
    logic [3:0]         r_map_kinds;
    logic [CFG_W-1:0]   r_first_lo;
    logic [CFG_W-1:0]   r_first_hi;
    logic [CFG_W-1:0]   r_first_to;
    logic [CFG_W-1:0]   r_second_lo;
    logic [CFG_W-1:0]   r_second_hi;
    logic [CFG_W-1:0]   r_second_to;

    t_bsh_state         r_state;
    t_bsh_state         n_state;
    logic [SYM_W-1:0]   r_clr_addr;
    logic [SYM_W-1:0]   r_addr;
    logic               r_kind;
    logic               r_last;
    logic               r_out_kind;
    logic [SYM_W-1:0]   r_out_sym;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_out_last;

    logic [WW-1:0]      width_ext;
    logic [HW-1:0]      width_eff;
    t_unp_ctl           unp_ctl;
    t_unp_sts           unp_sts;
    logic [SYM_W-1:0]   raw_sym;
    logic [SYM_W-1:0]   mapped_sym;
    logic               ram_we;
    logic [SYM_W-1:0]   ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [CNT_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   n_cnt;
    logic               accept;

    // width clamp: zero acts as one, too wide acts as the maximum
    always_comb begin
        width_ext = WW'(r_symbol_width);
        if (width_ext == '0) begin
            width_eff = HW'(1);
        end else if (width_ext > WW'(SYM_W)) begin
            width_eff = HW'(SYM_W);
        end else begin
            width_eff = HW'(width_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_width <= RESET_SYMBOL_WIDTH;
            r_map_kinds    <= '0;
            r_first_lo     <= '0;
            r_first_hi     <= '0;
            r_first_to     <= '0;
            r_second_lo    <= '0;
            r_second_hi    <= '0;
            r_second_to    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SYMBOL_WIDTH:     r_symbol_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_MAP_KINDS:        r_map_kinds    <= i_cfg_data[3:0];
                CFG_FIRST_FROM_LOW:   r_first_lo     <= i_cfg_data;
                CFG_FIRST_FROM_HIGH:  r_first_hi     <= i_cfg_data;
                CFG_FIRST_TO_START:   r_first_to     <= i_cfg_data;
                CFG_SECOND_FROM_LOW:  r_second_lo    <= i_cfg_data;
                CFG_SECOND_FROM_HIGH: r_second_hi    <= i_cfg_data;
                CFG_SECOND_TO_START:  r_second_to    <= i_cfg_data;
                default:              r_map_kinds    <= r_map_kinds;
            endcase
        end
    end

    bsh_unpack #(
        .SYM_W (SYM_W)
    ) u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (unp_ctl),
        .i_byte  (i_data_byte),
        .i_eos   (i_end_of_stream),
        .i_width (width_eff),
        .o_sym   (raw_sym),
        .o_sts   (unp_sts)
    );

    bsh_remap #(
        .SYM_W (SYM_W)
    ) u_remap (
        .i_kinds (r_map_kinds),
        .i_lo0   (r_first_lo),
        .i_hi0   (r_first_hi),
        .i_to0   (r_first_to),
        .i_lo1   (r_second_lo),
        .i_hi1   (r_second_hi),
        .i_to1   (r_second_to),
        .i_sym   (raw_sym),
        .o_sym   (mapped_sym)
    );

    bsh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // saturating increment
    assign n_cnt  = (&ram_rdata) ? ram_rdata : ram_rdata + CNT_W'(1);
    assign accept = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_mode ? S_READ : S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (unp_sts.sym_done) begin
                    n_state = S_READ;
                end else if (unp_sts.byte_end) begin
                    n_state = S_IDLE;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = (r_kind || unp_sts.byte_done) ? S_IDLE : S_SHIFT;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != S_IDLE);
        o_valid       = (r_state == S_OUT);
        unp_ctl.load  = accept && !i_mode;
        unp_ctl.shift = (r_state == S_SHIFT);
        unp_ctl.clear = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_SYMBOL_WIDTH);
        ram_we        = (r_state == S_CLEAR) || ((r_state == S_UPDATE) && !r_kind);
        ram_waddr     = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        ram_wdata     = (r_state == S_CLEAR) ? '0 : n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_kind     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + SYM_W'(1);
            end
            if (accept) begin
                r_kind <= i_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_mode) begin
            r_addr <= i_bin_index;
            r_last <= 1'b1;
        end else if (unp_sts.sym_done) begin
            r_addr <= mapped_sym;
            r_last <= unp_sts.run_last;
        end
        if (r_state == S_UPDATE) begin
            r_out_kind <= r_kind;
            r_out_sym  <= r_addr;
            r_out_cnt  <= r_kind ? ram_rdata : n_cnt;
            r_out_last <= r_last;
        end
    end

    assign o_reply_kind   = r_out_kind;
    assign o_symbol_value = r_out_sym;
    assign o_bin_count    = r_out_cnt;
    assign o_last_of_run  = r_out_last;

endmodule

### rtl/bsh_ram.sv
// ----------------------------------------------------------------------------
// bsh_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bsh_unpack.sv
// ----------------------------------------------------------------------------
// bsh_unpack
// Bit-serial symbol cutter: shifts a byte out msb first into a symbol
// register and flags each completed or flushed symbol.
// ----------------------------------------------------------------------------
module bsh_unpack #(
    parameter int SYM_W = bsh_pkg::MAX_SYMBOL_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsh_pkg::t_unp_ctl            i_ctl,
    input  logic [bsh_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_eos,
    input  logic [$clog2(SYM_W+1)-1:0]   i_width,
    output logic [SYM_W-1:0]             o_sym,
    output bsh_pkg::t_unp_sts            o_sts
);

    import bsh_pkg::*;

    localparam int HW = $clog2(SYM_W + 1);
    localparam int CW = (HW > LEFT_W) ? HW : LEFT_W;

    logic [SYM_W-1:0]  r_sym;
    logic [HW-1:0]     r_held;
    logic [BYTE_W-1:0] r_byte;
    logic [LEFT_W-1:0] r_left;
    logic              r_eos;

    logic [SYM_W-1:0]  n_sym;
    logic [HW-1:0]     n_held;
    logic [LEFT_W-1:0] n_left;
    logic              full;
    logic              flush;
    logic              done;

    always_comb begin
        n_sym  = (r_sym << 1) | SYM_W'(r_byte[BYTE_W-1]);
        n_held = r_held + HW'(1);
        n_left = r_left - LEFT_W'(1);
        full   = (n_held == i_width);
        flush  = (n_left == '0) && r_eos && !full;
        done   = full || flush;
    end

    assign o_sym           = n_sym;
    assign o_sts.sym_done  = i_ctl.shift && done;
    assign o_sts.run_last  = flush
                           || ((CW'(n_left) < CW'(i_width)) && !(r_eos && (n_left != '0)));
    assign o_sts.byte_end  = (n_left == '0);
    assign o_sts.byte_done = (r_left == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym  <= '0;
            r_held <= '0;
            r_left <= '0;
            r_eos  <= 1'b0;
        end else if (i_ctl.clear) begin
            r_sym  <= '0;
            r_held <= '0;
        end else if (i_ctl.load) begin
            r_left <= LEFT_W'(BYTE_W);
            r_eos  <= i_eos;
        end else if (i_ctl.shift) begin
            r_left <= n_left;
            if (done) begin
                r_sym  <= '0;
                r_held <= '0;
            end else begin
                r_sym  <= n_sym;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_byte;
        end else if (i_ctl.shift) begin
            r_byte <= r_byte << 1;
        end
    end

endmodule

### rtl/bsh_remap.sv
// ----------------------------------------------------------------------------
// bsh_remap
// Symbol remapper: two ranges, ascending, descending or single target,
// with range one taking priority over range zero.
// ----------------------------------------------------------------------------
module bsh_remap #(
    parameter int SYM_W = bsh_pkg::MAX_SYMBOL_BITS
) (
    input  logic [3:0]                 i_kinds,
    input  logic [bsh_pkg::CFG_W-1:0]  i_lo0,
    input  logic [bsh_pkg::CFG_W-1:0]  i_hi0,
    input  logic [bsh_pkg::CFG_W-1:0]  i_to0,
    input  logic [bsh_pkg::CFG_W-1:0]  i_lo1,
    input  logic [bsh_pkg::CFG_W-1:0]  i_hi1,
    input  logic [bsh_pkg::CFG_W-1:0]  i_to1,
    input  logic [SYM_W-1:0]           i_sym,
    output logic [SYM_W-1:0]           o_sym
);

    import bsh_pkg::*;

    localparam int RW = (SYM_W > CFG_W) ? SYM_W : CFG_W;

    t_map_kind        kind0;
    t_map_kind        kind1;
    logic             hit0;
    logic             hit1;
    logic [SYM_W-1:0] res0;
    logic [SYM_W-1:0] res1;

    always_comb begin
        kind0 = t_map_kind'(i_kinds[1:0]);
        kind1 = t_map_kind'(i_kinds[3:2]);
        hit0  = (kind0 != MAP_OFF) && (RW'(i_sym) >= RW'(i_lo0))
              && (RW'(i_sym) <= RW'(i_hi0));
        hit1  = (kind1 != MAP_OFF) && (RW'(i_sym) >= RW'(i_lo1))
              && (RW'(i_sym) <= RW'(i_hi1));

        case (kind0)
            MAP_ASC:  res0 = SYM_W'(i_to0) + (i_sym - SYM_W'(i_lo0));
            MAP_DESC: res0 = SYM_W'(i_to0) - (i_sym - SYM_W'(i_lo0));
            default:  res0 = SYM_W'(i_to0);
        endcase

        case (kind1)
            MAP_ASC:  res1 = SYM_W'(i_to1) + (i_sym - SYM_W'(i_lo1));
            MAP_DESC: res1 = SYM_W'(i_to1) - (i_sym - SYM_W'(i_lo1));
            default:  res1 = SYM_W'(i_to1);
        endcase

        if (hit1) begin
            o_sym = res1;
        end else if (hit0) begin
            o_sym = res0;
        end else begin
            o_sym = i_sym;
        end
    end

endmodule
